// ===== hdl/ptw_pkg.sv =====
// Shared types, codes and helpers for the page table walker.
// Used by every module of the walker and by its port checker; no dependencies.
package ptw_pkg;

  localparam int PHYS_ADDR_BITS_DEF = 56;

  localparam int VaW      = 39;
  localparam int PteW     = 64;
  localparam int PpnW     = 44;
  localparam int PaW      = 56;
  localparam int InDataW  = 112;
  localparam int OutDataW = 184;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // input command
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PTE   = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_FAULT = 2'd3;

  // fault codes
  localparam logic [2:0] FLT_INVALID    = 3'd0;
  localparam logic [2:0] FLT_MISALIGNED = 3'd1;
  localparam logic [2:0] FLT_PERM       = 3'd2;
  localparam logic [2:0] FLT_BAD_NONLEAF = 3'd3;
  localparam logic [2:0] FLT_NO_LEAF    = 3'd4;

  // access kinds
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  // register indexes (8-byte stride)
  localparam logic [2:0] REG_TEN  = 3'd0;
  localparam logic [2:0] REG_SV39 = 3'd1;
  localparam logic [2:0] REG_ROOT = 3'd2;
  localparam logic [2:0] REG_SUM  = 3'd3;
  localparam logic [2:0] REG_MXR  = 3'd4;

  typedef struct packed {
    logic            ten;
    logic            sv39;
    logic [PpnW-1:0] root_ppn;
    logic            sum;
    logic            mxr;
  } cfg_t;

  typedef struct packed {
    logic            cmd;
    logic [VaW-1:0]  vaddr;
    logic            priv;
    logic [1:0]      access;
    logic            internal;
    logic [PteW-1:0] pte;
  } item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PaW-1:0]  mem_addr;
    logic [PteW-1:0] write_data;
    logic [PaW-1:0]  phys_addr;
    logic [2:0]      fault_code;
    logic            written;
    logic            last;
  } result_t;

  // Byte offset of the PTE inside its table for the given level.
  function automatic logic [11:0] pte_offset(input logic [VaW-1:0] va,
                                             input logic [1:0] lvl,
                                             input logic sv39);
    logic [9:0] idx;
    idx = '0;
    if (sv39) begin
      case (lvl)
        2'd0:    idx = {1'b0, va[20:12]};
        2'd1:    idx = {1'b0, va[29:21]};
        2'd2:    idx = {1'b0, va[38:30]};
        default: idx = '0;
      endcase
      return {idx[8:0], 3'b000};
    end
    case (lvl)
      2'd0:    idx = va[21:12];
      2'd1:    idx = va[31:22];
      2'd2:    idx = {3'b000, va[38:32]};
      default: idx = '0;
    endcase
    return {idx, 2'b00};
  endfunction

endpackage

// ===== hdl/page_table_walk.sv =====
// Channel  Dir  Handshake              Word
// in_      in   in_tvalid/in_tready    in_tuser cmd, in_tdata start or PTE fields
// out_     out  out_tvalid/out_tready  out_tuser kind, out_tdata result, out_tlast
// cfg_     in   psel/penable/pwrite    64-bit registers at 8-byte stride
//
// One item per cycle sustained while the result queue has room; a result word is
// offered after the input register and the result queue (read straight out).
// A leaf that needs its A/D bits updated yields two words; a run of such leaves
// is paced by the four-entry result queue.
// Stalls on out_ propagate back to in_tready once the queue holds more than two.
// Reset (rst_n low, synchronous) empties the queue and idles the walk.
// Depends on ptw_pkg, ptw_cfg, ptw_core and ptw_outq.
module page_table_walk #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // vaddr[38:0], priv_level[39], access_kind[41:40], internal_access[42],
  // pte_data[106:43], zero fill above
  input  logic [ptw_pkg::InDataW-1:0]   in_tdata,
  // cmd
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // mem_addr[55:0], write_data[119:56], phys_addr[175:120], fault_code[178:176],
  // pte_updated[179], zero fill above
  output logic [ptw_pkg::OutDataW-1:0]  out_tdata,
  // result_kind
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ptw_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [ptw_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [ptw_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import ptw_pkg::*;

  cfg_t       cfg;
  item_t      item;
  result_t    res0, res1, out_res;
  logic [1:0] push_cnt;
  logic       q_room;

  always_comb begin
    item.cmd      = in_tuser;
    item.vaddr    = in_tdata[38:0];
    item.priv     = in_tdata[39];
    item.access   = in_tdata[41:40];
    item.internal = in_tdata[42];
    item.pte      = in_tdata[106:43];
  end

  ptw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ptw_core #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (item),
    .q_room   (q_room),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  ptw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'd0, out_res.written, out_res.fault_code, out_res.phys_addr,
                      out_res.write_data, out_res.mem_addr};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ===== hdl/ptw_cfg.sv =====
// Configuration registers of the walker behind an APB-style port.
// Depends on ptw_pkg.
module ptw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptw_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ptw_pkg::CfgDataW-1:0]  pwdata,
  output logic [ptw_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ptw_pkg::cfg_t                 cfg
);
  import ptw_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CfgAddrW-1:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEN:  cfg_r.ten      <= pwdata[0];
        REG_SV39: cfg_r.sv39     <= pwdata[0];
        REG_ROOT: cfg_r.root_ppn <= pwdata[PpnW-1:0];
        REG_SUM:  cfg_r.sum      <= pwdata[0];
        REG_MXR:  cfg_r.mxr      <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TEN:  prdata[0]        = cfg_r.ten;
      REG_SV39: prdata[0]        = cfg_r.sv39;
      REG_ROOT: prdata[PpnW-1:0] = cfg_r.root_ppn;
      REG_SUM:  prdata[0]        = cfg_r.sum;
      REG_MXR:  prdata[0]        = cfg_r.mxr;
      default:  prdata           = '0;
    endcase
  end

endmodule

// ===== hdl/ptw_core.sv =====
// Walker datapath: input register, one-pass PTE check and walk state.
// Depends on ptw_pkg; pushes up to two result words per item into ptw_outq.
module ptw_core #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptw_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptw_pkg::item_t    in_item,
  input  logic              q_room,
  output logic [1:0]        push_cnt,
  output ptw_pkg::result_t  res0,
  output ptw_pkg::result_t  res1
);
  import ptw_pkg::*;

  localparam logic [PaW-1:0] PaMask = PaW'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

  logic           s1_valid_r, s1_valid_nxt;
  item_t          s1_item_r;
  logic           fire;

  logic           busy_r, busy_nxt;
  logic [1:0]     level_r, level_nxt;
  logic [VaW-1:0] va_r, va_nxt;
  logic [1:0]     acc_r, acc_nxt;
  logic           priv_r, priv_nxt;
  logic           int_r, int_nxt;
  logic [PaW-1:0] walk_addr_r, walk_addr_nxt;

  logic [VaW-1:0]  start_va;
  logic [1:0]      start_lvl;
  logic [PpnW-1:0] start_ppn;
  logic [PteW-1:0] pte;
  logic [PpnW-1:0] ppn;
  logic            pte_v, pte_r, pte_w, pte_x, pte_u;
  logic            misaligned;
  logic            perm_ok;
  logic [5:0]      off_bits;
  logic [PaW-1:0]  off_mask;
  logic [PaW-1:0]  leaf_pa;
  logic            set_d, set_a;
  logic [PteW-1:0] new_pte;
  logic [1:0]      down_lvl;

  assign fire     = s1_valid_r && q_room;
  assign in_ready = !s1_valid_r || fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (fire) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_item;
  end

  // PTE decode
  always_comb begin
    pte   = cfg.sv39 ? s1_item_r.pte : {32'd0, s1_item_r.pte[31:0]};
    ppn   = cfg.sv39 ? pte[53:10] : {22'd0, pte[31:10]};
    pte_v = pte[0];
    pte_r = pte[1];
    pte_w = pte[2];
    pte_x = pte[3];
    pte_u = pte[4];

    case (level_r)
      2'd0:    misaligned = 1'b0;
      2'd1:    misaligned = cfg.sv39 ? |ppn[8:0]  : |ppn[9:0];
      2'd2:    misaligned = cfg.sv39 ? |ppn[17:0] : |ppn[19:0];
      default: misaligned = cfg.sv39 ? |ppn[26:0] : |ppn[29:0];
    endcase

    case (level_r)
      2'd0:    off_bits = 6'd12;
      2'd1:    off_bits = cfg.sv39 ? 6'd21 : 6'd22;
      2'd2:    off_bits = cfg.sv39 ? 6'd30 : 6'd32;
      default: off_bits = cfg.sv39 ? 6'd39 : 6'd42;
    endcase
    off_mask = PaW'((64'd1 << off_bits) - 64'd1);
    leaf_pa  = (({ppn, 12'd0} & ~off_mask) | ({{(PaW-VaW){1'b0}}, va_r} & off_mask))
               & PaMask;

    // user pages need U; supervisor on U pages needs SUM and no fetch
    perm_ok = 1'b1;
    if (!priv_r) begin
      if (!pte_u) perm_ok = 1'b0;
    end else if (pte_u) begin
      if (!cfg.sum || acc_r == ACC_FETCH) perm_ok = 1'b0;
    end
    case (acc_r)
      ACC_READ:  perm_ok = perm_ok && (pte_r || (cfg.mxr && pte_x));
      ACC_WRITE: perm_ok = perm_ok && pte_w;
      ACC_FETCH: perm_ok = perm_ok && pte_x;
      default:   perm_ok = 1'b0;
    endcase

    set_d   = (acc_r == ACC_WRITE) && !pte[7];
    set_a   = !int_r && !pte[6];
    new_pte = pte | {56'd0, set_d, set_a, 6'd0};
    down_lvl = level_r - 2'd1;
  end

  // start decode
  always_comb begin
    start_va  = cfg.sv39 ? s1_item_r.vaddr : {7'd0, s1_item_r.vaddr[31:0]};
    start_lvl = cfg.sv39 ? 2'd2 : 2'd1;
    start_ppn = cfg.sv39 ? cfg.root_ppn : {22'd0, cfg.root_ppn[21:0]};
  end

  always_comb begin
    busy_nxt      = busy_r;
    level_nxt     = level_r;
    va_nxt        = va_r;
    acc_nxt       = acc_r;
    priv_nxt      = priv_r;
    int_nxt       = int_r;
    walk_addr_nxt = walk_addr_r;
    push_cnt      = 2'd0;
    res0          = '0;
    res1          = '0;
    res0.last     = 1'b1;

    if (fire) begin
      if (s1_item_r.cmd == CMD_START) begin
        acc_nxt  = s1_item_r.access;
        priv_nxt = s1_item_r.priv;
        int_nxt  = s1_item_r.internal;
        push_cnt = 2'd1;
        if (!cfg.ten) begin
          va_nxt         = s1_item_r.vaddr;
          busy_nxt       = 1'b0;
          res0.kind      = KIND_DONE;
          res0.phys_addr = {{(PaW-VaW){1'b0}}, s1_item_r.vaddr} & PaMask;
        end else begin
          va_nxt        = start_va;
          level_nxt     = start_lvl;
          busy_nxt      = 1'b1;
          walk_addr_nxt = {start_ppn, pte_offset(start_va, start_lvl, cfg.sv39)} & PaMask;
          res0.kind     = KIND_READ;
          res0.mem_addr = walk_addr_nxt;
        end
      end else if (busy_r) begin
        push_cnt = 2'd1;
        if (!pte_v) begin
          busy_nxt        = 1'b0;
          res0.kind       = KIND_FAULT;
          res0.fault_code = FLT_INVALID;
        end else if (pte_r || pte_x) begin
          busy_nxt = 1'b0;
          if (misaligned) begin
            res0.kind       = KIND_FAULT;
            res0.fault_code = FLT_MISALIGNED;
          end else if (!perm_ok) begin
            res0.kind       = KIND_FAULT;
            res0.fault_code = FLT_PERM;
          end else if (set_d || set_a) begin
            // write back the updated PTE first, then report the address
            push_cnt        = 2'd2;
            res0.kind       = KIND_WRITE;
            res0.mem_addr   = walk_addr_r;
            res0.write_data = new_pte;
            res0.written    = 1'b1;
            res0.last       = 1'b0;
            res1.kind       = KIND_DONE;
            res1.phys_addr  = leaf_pa;
            res1.written    = 1'b1;
            res1.last       = 1'b1;
          end else begin
            res0.kind      = KIND_DONE;
            res0.phys_addr = leaf_pa;
          end
        end else if (pte_w) begin
          busy_nxt        = 1'b0;
          res0.kind       = KIND_FAULT;
          res0.fault_code = FLT_BAD_NONLEAF;
        end else if (level_r == 2'd0) begin
          busy_nxt        = 1'b0;
          res0.kind       = KIND_FAULT;
          res0.fault_code = FLT_NO_LEAF;
        end else begin
          level_nxt     = down_lvl;
          walk_addr_nxt = {ppn, pte_offset(va_r, down_lvl, cfg.sv39)} & PaMask;
          res0.kind     = KIND_READ;
          res0.mem_addr = walk_addr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r        <= va_nxt;
    acc_r       <= acc_nxt;
    priv_r      <= priv_nxt;
    int_r       <= int_nxt;
    walk_addr_r <= walk_addr_nxt;
  end

endmodule

// ===== hdl/ptw_outq.sv =====
// Result queue of the walker: takes one or two words a cycle, hands out one.
// Depends on ptw_pkg.
module ptw_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  ptw_pkg::result_t  push0,
  input  ptw_pkg::result_t  push1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ptw_pkg::result_t  out_res
);
  import ptw_pkg::*;

  result_t          q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // keep space for the two words one item may bring
  assign room      = (cnt_r <= QCntW'(QDepth - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    cnt_nxt    = cnt_r + QCntW'(push_cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) q_r[QPtrW'(wr_ptr_r + QPtrW'(1))] <= push1;
  end

endmodule

// ===== hdl/ptw_checker.sv =====
// Port-level checks on the walker's result channel, bound to page_table_walk.
// Depends on ptw_pkg.
module ptw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ptw_pkg::OutDataW-1:0]  out_tdata,
  input logic [1:0]                    out_tuser,
  input logic                          out_tlast
);
  import ptw_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a write-back is never the final word and always flags the update
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_WRITE |-> !out_tlast && out_tdata[179])
    else $error("write-back word marked last or unflagged");

  // every other word closes its item
  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_WRITE |-> out_tlast)
    else $error("non-write word not marked last");

  // a fault carries no addresses
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FAULT |-> out_tdata[55:0] == '0 &&
    out_tdata[175:120] == '0 && !out_tdata[179])
    else $error("fault word carries address bits");

endmodule

bind page_table_walk ptw_checker u_ptw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/page_table_walk_test.sv =====
// Self-checking bench for page_table_walk: drives start and PTE words, programs
// the APB registers between phases and predicts every result word in a scoreboard.
// Depends on ptw_pkg and page_table_walk.
module page_table_walk_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam logic [1:0] ACC_BAD = 2'd3;
  localparam logic PRIV_USER = 1'b0;
  localparam logic PRIV_SUP  = 1'b1;

  localparam logic [7:0] PTE_V = 8'h01;
  localparam logic [7:0] PTE_R = 8'h02;
  localparam logic [7:0] PTE_W = 8'h04;
  localparam logic [7:0] PTE_X = 8'h08;
  localparam logic [7:0] PTE_U = 8'h10;
  localparam logic [7:0] PTE_A = 8'h40;
  localparam logic [7:0] PTE_D = 8'h80;

  localparam logic [PpnW-1:0] ROOT_MAX = '1;
  localparam logic [VaW-1:0]  VA_MAX   = '1;

  class walk_scoreboard;
    logic            ten  = 1'b0;
    logic            sv39 = 1'b0;
    logic [PpnW-1:0] root = '0;
    logic            sum  = 1'b0;
    logic            mxr  = 1'b0;

    logic            busy      = 1'b0;
    logic [1:0]      level     = '0;
    logic [PpnW-1:0] tppn      = '0;
    logic [VaW-1:0]  va        = '0;
    logic [1:0]      acc       = '0;
    logic            priv      = 1'b0;
    logic            intl      = 1'b0;
    logic [PaW-1:0]  walk_addr = '0;

    result_t pending_results[$];
    int      errors = 0;

    function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_TEN:  ten  = value[0];
        REG_SV39: sv39 = value[0];
        REG_ROOT: root = value[PpnW-1:0];
        REG_SUM:  sum  = value[0];
        REG_MXR:  mxr  = value[0];
        default:  ;
      endcase
    endfunction

    function logic [PaW-1:0] entry_addr(logic [PpnW-1:0] ppn, logic [1:0] lvl);
      int          vb;
      logic [63:0] idx;
      vb  = sv39 ? 9 : 10;
      idx = (64'(va) >> (12 + lvl * vb)) & ((64'd1 << vb) - 64'd1);
      return PaW'((64'(ppn) << 12) + idx * (sv39 ? 64'd8 : 64'd4));
    endfunction

    function void push(logic [1:0] kind, logic [PaW-1:0] maddr, logic [63:0] wdata,
                       logic [PaW-1:0] pa, logic [2:0] fcode, logic wr, logic lst);
      result_t r;
      r.kind       = kind;
      r.mem_addr   = maddr;
      r.write_data = wdata;
      r.phys_addr  = pa;
      r.fault_code = fcode;
      r.written    = wr;
      r.last       = lst;
      pending_results.push_back(r);
    endfunction

    function void fault(logic [2:0] code);
      busy = 1'b0;
      push(KIND_FAULT, '0, '0, '0, code, 1'b0, 1'b1);
    endfunction

    function bit perm_ok(logic [63:0] pte);
      if (priv == PRIV_USER) begin
        if (!pte[4]) return 1'b0;
      end else if (pte[4]) begin
        if (!sum || acc == ACC_FETCH) return 1'b0;
      end
      case (acc)
        ACC_READ:  return pte[1] || (mxr && pte[3]);
        ACC_WRITE: return pte[2];
        ACC_FETCH: return pte[3];
        default:   return 1'b0;
      endcase
    endfunction

    function void note_input(item_t it);
      logic [63:0]     pte;
      logic [63:0]     npte;
      logic [63:0]     lowmask;
      logic [63:0]     offmask;
      logic [63:0]     pa;
      logic [PpnW-1:0] ppn;
      int              sh;
      bit              wr;
      if (it.cmd == CMD_START) begin
        va   = it.vaddr;
        priv = it.priv;
        acc  = it.access;
        intl = it.internal;
        if (!ten) begin
          busy = 1'b0;
          push(KIND_DONE, '0, '0, PaW'(va), '0, 1'b0, 1'b1);
          return;
        end
        if (!sv39) va[VaW-1:32] = '0;
        level     = sv39 ? 2'd2 : 2'd1;
        tppn      = sv39 ? root : {22'b0, root[21:0]};
        walk_addr = entry_addr(tppn, level);
        busy      = 1'b1;
        push(KIND_READ, walk_addr, '0, '0, '0, 1'b0, 1'b1);
        return;
      end
      // a PTE word with no walk in flight is dropped
      if (!busy) return;
      pte = sv39 ? it.pte : {32'b0, it.pte[31:0]};
      ppn = sv39 ? pte[53:10] : {22'b0, pte[31:10]};
      if (!pte[0]) begin
        fault(FLT_INVALID);
        return;
      end
      if (pte[1] || pte[3]) begin
        sh      = level * (sv39 ? 9 : 10);
        lowmask = (64'd1 << sh) - 64'd1;
        if (level != 0 && (64'(ppn) & lowmask) != 0) begin
          fault(FLT_MISALIGNED);
          return;
        end
        if (!perm_ok(pte)) begin
          fault(FLT_PERM);
          return;
        end
        npte = pte;
        wr   = 1'b0;
        if (acc == ACC_WRITE && !pte[7]) begin
          npte[7] = 1'b1;
          wr      = 1'b1;
        end
        if (!intl && !pte[6]) begin
          npte[6] = 1'b1;
          wr      = 1'b1;
        end
        offmask = (64'd1 << (12 + sh)) - 64'd1;
        pa      = ((64'(ppn) << 12) & ~offmask) | (64'(va) & offmask);
        busy    = 1'b0;
        if (wr) begin
          push(KIND_WRITE, walk_addr, npte, '0, '0, 1'b1, 1'b0);
          push(KIND_DONE, '0, '0, PaW'(pa), '0, 1'b1, 1'b1);
        end else begin
          push(KIND_DONE, '0, '0, PaW'(pa), '0, 1'b0, 1'b1);
        end
        return;
      end
      if (pte[2]) begin
        fault(FLT_BAD_NONLEAF);
        return;
      end
      if (level == 0) begin
        fault(FLT_NO_LEAF);
        return;
      end
      level     = level - 2'd1;
      tppn      = ppn;
      walk_addr = entry_addr(tppn, level);
      push(KIND_READ, walk_addr, '0, '0, '0, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, actual kind %h tdata %h",
                 $time, got.kind, {got.mem_addr, got.write_data, got.phys_addr});
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(got.kind));
      compare_field("mem_addr", 64'(want.mem_addr), 64'(got.mem_addr));
      compare_field("write_data", want.write_data, got.write_data);
      compare_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
      compare_field("fault_code", 64'(want.fault_code), 64'(got.fault_code));
      compare_field("pte_updated", 64'(want.written), 64'(got.written));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic                in_tuser    = 1'b0;
  logic                out_tvalid;
  logic                out_tready  = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  walk_scoreboard sb;
  result_t        seen_word;
  int             stall_left     = 0;
  int             in_gap_pct     = 20;
  int             out_stall_pct  = 20;
  int             accepted_items = 0;
  bit             calm           = 1'b0;

  page_table_walk uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // take result words and stall the receiver in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word.kind       = out_tuser;
      seen_word.mem_addr   = out_tdata[55:0];
      seen_word.write_data = out_tdata[119:56];
      seen_word.phys_addr  = out_tdata[175:120];
      seen_word.fault_code = out_tdata[178:176];
      seen_word.written    = out_tdata[179];
      seen_word.last       = out_tlast;
      sb.check_result(seen_word);
    end
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 13);
    end
  end

  initial begin
    #5_000_000;
    $display("page_table_walk verification failed");
    $finish;
  end

  function automatic logic [63:0] make_pte(logic [PpnW-1:0] ppn, logic [7:0] flags);
    return {10'b0, ppn, 2'b00, flags};
  endfunction

  task automatic send_word(input item_t it);
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {5'b0, it.pte, it.internal, it.access, it.priv, it.vaddr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.cmd == CMD_START || sb.busy) accepted_items++;
    sb.note_input(it);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic start_at(logic [VaW-1:0] va, logic priv, logic [1:0] acc, logic intl);
    item_t it;
    it          = '0;
    it.cmd      = CMD_START;
    it.vaddr    = va;
    it.priv     = priv;
    it.access   = acc;
    it.internal = intl;
    it.pte      = {$urandom(), $urandom()};
    send_word(it);
  endtask

  task automatic give_pte(logic [63:0] pte);
    item_t it;
    it.cmd      = CMD_PTE;
    it.vaddr    = VaW'({$urandom(), $urandom()});
    it.priv     = 1'($urandom_range(0, 1));
    it.access   = 2'($urandom_range(0, 3));
    it.internal = 1'($urandom_range(0, 1));
    it.pte      = pte;
    send_word(it);
  endtask

  task automatic random_start();
    start_at(VaW'({$urandom(), $urandom()}), 1'($urandom_range(0, 1)),
             ($urandom_range(0, 19) == 0) ? ACC_BAD : 2'($urandom_range(0, 2)),
             $urandom_range(0, 3) == 0);
  endtask

  // shape a PTE for the current level so that most walks reach a leaf
  task automatic random_pte();
    logic [63:0] pte;
    int          pick;
    int          sh;
    pte  = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    sh   = sb.level * (sb.sv39 ? 9 : 10);
    if (pick < 5) begin
      pte[0] = 1'b0;
    end else begin
      pte[0] = 1'b1;
      if (pick < 9) begin
        pte[3:1] = 3'b010;
      end else if (pick < ((sb.level != 0) ? 60 : 14)) begin
        pte[3:1] = 3'b000;
      end else begin
        case (sb.acc)
          ACC_READ: begin
            if (sb.mxr && $urandom_range(0, 1) == 1) pte[3:1] = 3'b100;
            else pte[1] = 1'b1;
          end
          ACC_WRITE: pte[2:1] = 2'b11;
          ACC_FETCH: pte[3] = 1'b1;
          default:   pte[1] = 1'b1;
        endcase
        pte[4] = (sb.priv == PRIV_USER) || (sb.sum && $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 9) == 0) pte[4:1] = 4'($urandom());
        if (sh != 0 && $urandom_range(0, 4) != 0) pte = pte & ~(((64'd1 << sh) - 64'd1) << 10);
      end
    end
    give_pte(pte);
  endtask

  task automatic random_walk();
    if ($urandom_range(0, 19) == 0) random_pte();
    random_start();
    while (sb.busy) begin
      if ($urandom_range(0, 49) == 0) random_start();
      else random_pte();
    end
  endtask

  // end any open walk, drain the results and let the pipeline go quiet
  task automatic settle();
    if (sb.busy) give_pte(64'h0);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_setting(logic ten, logic sv39, logic [PpnW-1:0] root,
                               logic sum, logic mxr);
    settle();
    write_reg(REG_TEN, 64'(ten));
    write_reg(REG_SV39, 64'(sv39));
    write_reg(REG_ROOT, 64'(root));
    write_reg(REG_SUM, 64'(sum));
    write_reg(REG_MXR, 64'(mxr));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin : main
    int              pcts [3];
    int              target;
    logic [PpnW-1:0] root_pick;
    pcts = '{0, 15, 40};
    sb = new;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // translation off after reset: addresses pass through
    start_at(VA_MAX, PRIV_SUP, ACC_WRITE, 1'b1);
    start_at('0, PRIV_USER, ACC_READ, 1'b0);
    give_pte('1);

    apply_setting(1'b1, 1'b1, ROOT_MAX, 1'b0, 1'b0);
    // full three-level walk ending in a 4K leaf that needs A set
    start_at(VA_MAX, PRIV_SUP, ACC_READ, 1'b0);
    give_pte(make_pte(ROOT_MAX, PTE_V));
    give_pte(make_pte(ROOT_MAX, PTE_V));
    give_pte(make_pte(ROOT_MAX, PTE_V | PTE_R));
    // misaligned gigapage
    start_at(39'h40_0000_1234, PRIV_USER, ACC_WRITE, 1'b0);
    give_pte(make_pte(44'h1, PTE_V | PTE_R | PTE_W | PTE_U));
    // aligned gigapage with A and D already set
    start_at(39'h12_3456_789A, PRIV_USER, ACC_FETCH, 1'b0);
    give_pte(make_pte(44'hABC << 18, PTE_V | PTE_X | PTE_U | PTE_A | PTE_D));
    // restart while busy, then an invalid PTE
    start_at(39'h7F_0000_0000, PRIV_SUP, ACC_READ, 1'b0);
    start_at(39'h00_FFFF_F000, PRIV_SUP, ACC_FETCH, 1'b1);
    give_pte(64'h0);
    // W without R or X is a bad pointer
    start_at(39'h15_5555_5555, PRIV_SUP, ACC_WRITE, 1'b0);
    give_pte(make_pte(44'h5, PTE_V | PTE_W));
    // pointers all the way down: no leaf
    start_at(39'h2A_AAAA_AAAA, PRIV_SUP, ACC_READ, 1'b1);
    give_pte(make_pte(44'h3, PTE_V));
    give_pte(make_pte(44'h4, PTE_V));
    give_pte(make_pte(44'h6, PTE_V));
    // undefined access kind fails the permission check
    start_at(39'h00_0000_0FFF, PRIV_SUP, ACC_BAD, 1'b0);
    give_pte(make_pte('0, PTE_V | PTE_R | PTE_W | PTE_X | PTE_A | PTE_D));
    // user access to a supervisor page
    start_at(39'h00_0000_0000, PRIV_USER, ACC_READ, 1'b0);
    give_pte(make_pte('0, PTE_V | PTE_R));

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 2))
        0:       root_pick = '0;
        1:       root_pick = ROOT_MAX;
        default: root_pick = PpnW'({$urandom(), $urandom()});
      endcase
      case (phase)
        0:       apply_setting(1'b1, 1'b0, ROOT_MAX, 1'b1, 1'b1);
        1:       apply_setting(1'b1, 1'b1, '0, 1'b0, 1'b0);
        default: apply_setting($urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)), root_pick,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      calm          = (phase == 7);
      in_gap_pct    = pcts[$urandom_range(0, 2)];
      out_stall_pct = pcts[$urandom_range(0, 2)];
      target        = accepted_items + 190;
      while (accepted_items < target) random_walk();
    end

    settle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("page_table_walk verification clean");
    end else begin
      $display("page_table_walk verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ptw_pkg.sv
hdl/ptw_cfg.sv
hdl/ptw_core.sv
hdl/ptw_outq.sv
hdl/page_table_walk.sv
hdl/ptw_checker.sv
test/page_table_walk_test.sv
